>>> rtl/core/stcm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stcm_pkg
// Shared types and constants of the segment tree cover measure block.
// ----------------------------------------------------------------------------
package stcm_pkg;

	// Coordinate and result widths are fixed by the interface.
	localparam int CoordW = 10;
	localparam int MeasW  = 9;

	typedef logic [CoordW-1:0] coord_t;
	typedef logic [MeasW-1:0]  meas_t;

	// Configuration register indexes.
	localparam logic REG_RANGE_LOW  = 1'b0;
	localparam logic REG_RANGE_HIGH = 1'b1;

	// Reset values of the configuration registers.
	localparam coord_t RANGE_LOW_RST  = 10'd0;
	localparam coord_t RANGE_HIGH_RST = 10'd256;

	// Operation codes.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

endpackage
`default_nettype wire

>>> rtl/core/segment_tree_cover_measure.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_tree_cover_measure
// Union length of a multiset of intervals, kept in a segment tree in memory.
// ----------------------------------------------------------------------------
// A refused request is answered directly from the idle state; an update
// walks each visited tree node through the registered node memory port
// in steps (read, decide, child reads, write back, return; the root has no return).
// Only one request is in flight at a time; the next is accepted once the
// sequencer is idle and the result slot is free or being emptied. Reset and
// every configuration write start a clearing pass through all 4*MAX_SPAN
// entries of the node memory; no request is accepted then.

module segment_tree_cover_measure #(
	parameter int MAX_SPAN    = 256,
	parameter int COVER_WIDTH = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	// Request channel
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire                   op,
	input  wire stcm_pkg::coord_t interval_low,
	input  wire stcm_pkg::coord_t interval_high,
	// Result channel
	output logic                  out_valid,
	input  wire                   out_stall,
	output stcm_pkg::meas_t       measure,
	output logic                  rejected,
	// Configuration port
	input  wire                   cfg_we,
	input  wire                   cfg_index,
	input  wire stcm_pkg::coord_t cfg_data
);

	// Tree geometry. Heap indexes stay below four times the span, and the
	// tree is at most clog2(span) levels deep below the root.
	localparam int NODE_COUNT = 4 * MAX_SPAN;
	localparam int AW         = $clog2(NODE_COUNT);
	localparam int LEN_W      = $clog2(MAX_SPAN + 1);
	localparam int DW         = COVER_WIDTH + LEN_W;
	localparam int LVL        = $clog2(MAX_SPAN) + 1;
	localparam int SPW        = $clog2(LVL);
	localparam int CW         = stcm_pkg::CoordW;

	// Sequencer state codes.
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RD    = 4'd2;
	localparam logic [3:0] S_DEC   = 4'd3;
	localparam logic [3:0] S_LEFT  = 4'd4;
	localparam logic [3:0] S_LW    = 4'd5;
	localparam logic [3:0] S_RIGHT = 4'd6;
	localparam logic [3:0] S_RW    = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;
	localparam logic [3:0] S_RET   = 4'd9;

	logic [3:0] state_q;

	// Configuration.
	stcm_pkg::coord_t range_low_q;
	stcm_pkg::coord_t range_high_q;

	// Node memory: each entry holds the signed cover count of a node and
	// the covered length below it. The root's covered length is the measure.
	logic [DW-1:0] node_mem [NODE_COUNT];
	logic [DW-1:0] mem_rdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [DW-1:0] mem_wdata;

	logic [AW-1:0] clr_q;

	// Explicit traversal stack, one frame per tree level on the active path.
	logic [AW-1:0]                 fr_idx [LVL];
	stcm_pkg::coord_t              fr_i   [LVL];
	stcm_pkg::coord_t              fr_j   [LVL];
	stcm_pkg::coord_t              fr_a   [LVL];
	stcm_pkg::coord_t              fr_b   [LVL];
	logic signed [COVER_WIDTH-1:0] fr_cnt [LVL];
	logic                          fr_vl  [LVL];
	logic                          fr_vr  [LVL];
	logic [LEN_W-1:0]              fr_lv  [LVL];
	logic [LEN_W-1:0]              fr_rv  [LVL];
	logic [SPW-1:0]                sp_q;

	logic             op_q;
	logic [LEN_W-1:0] ret_q;
	logic             ret_right_q;
	logic [LEN_W-1:0] root_len_q;

	// Result register.
	logic            out_valid_q;
	stcm_pkg::meas_t res_measure_q;
	logic            res_rejected_q;

	// Top-of-stack view.
	logic [AW-1:0]                 t_idx;
	stcm_pkg::coord_t              t_i, t_j, t_a, t_b;
	logic signed [COVER_WIDTH-1:0] t_cnt;
	logic [CW:0]                   mid_sum;
	stcm_pkg::coord_t              t_mid;
	stcm_pkg::coord_t              t_len;
	logic                          t_leaf;
	logic                          t_full;
	logic [AW-1:0]                 idx_l, idx_r;
	stcm_pkg::coord_t              left_b, right_a;

	// Node data coming back from memory.
	logic signed [COVER_WIDTH-1:0] rd_cnt;
	logic [LEN_W-1:0]              rd_cov;
	logic [COVER_WIDTH:0]          cnt_sum;
	logic signed [COVER_WIDTH-1:0] cnt_new;

	// Write-back value of the top node.
	logic [LEN_W:0]   child_sum;
	logic [LEN_W-1:0] fin_cov;

	// Request checks.
	stcm_pkg::coord_t range_span;
	logic             range_ok;
	logic             req_reject;
	logic             in_accept;
	logic             out_take;

	assign range_span = range_high_q - range_low_q;
	assign range_ok   = (range_high_q > range_low_q) &&
		({1'b0, range_span} <= (CW+1)'(MAX_SPAN));
	assign req_reject = !range_ok || (interval_high <= interval_low) ||
		(interval_low < range_low_q) || (interval_high > range_high_q);

	// A request is taken only while the sequencer is idle and the result
	// slot is free or being emptied, so a result always has a place to land.
	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign in_accept = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;

	assign out_valid = out_valid_q;
	assign measure   = res_measure_q;
	assign rejected  = res_rejected_q;

	assign t_idx   = fr_idx[sp_q];
	assign t_i     = fr_i[sp_q];
	assign t_j     = fr_j[sp_q];
	assign t_a     = fr_a[sp_q];
	assign t_b     = fr_b[sp_q];
	assign t_cnt   = fr_cnt[sp_q];
	assign mid_sum = {1'b0, t_i} + {1'b0, t_j};
	assign t_mid   = mid_sum[CW:1];
	assign t_len   = t_j - t_i;
	assign t_leaf  = (t_len <= CW'(1));
	assign t_full  = (t_a <= t_i) && (t_j <= t_b);
	assign idx_l   = {t_idx[AW-2:0], 1'b0};
	assign idx_r   = {t_idx[AW-2:0], 1'b1};
	assign left_b  = (t_b < t_mid) ? t_b : t_mid;
	assign right_a = (t_a > t_mid) ? t_a : t_mid;

	assign rd_cnt = mem_rdata[DW-1 -: COVER_WIDTH];
	assign rd_cov = mem_rdata[LEN_W-1:0];

	// Saturating step of the count: overflow shows as a mismatch of the two
	// top bits of the widened sum, whose top bit then gives the direction.
	always_comb begin
		cnt_sum = {rd_cnt[COVER_WIDTH-1], rd_cnt} +
			((op_q == stcm_pkg::OP_DELETE) ? {(COVER_WIDTH+1){1'b1}} :
			(COVER_WIDTH+1)'(1));
		if (cnt_sum[COVER_WIDTH] != cnt_sum[COVER_WIDTH-1]) begin
			cnt_new = cnt_sum[COVER_WIDTH] ? {1'b1, {(COVER_WIDTH-1){1'b0}}} :
				{1'b0, {(COVER_WIDTH-1){1'b1}}};
		end else begin
			cnt_new = cnt_sum[COVER_WIDTH-1:0];
		end
	end

	// A covered node counts its whole length; otherwise a leaf counts
	// nothing and an inner node the sum of its children.
	always_comb begin
		child_sum = {1'b0, fr_lv[sp_q]} + {1'b0, fr_rv[sp_q]};
		if (t_cnt > 0) begin
			fin_cov = LEN_W'(t_len);
		end else if (t_leaf) begin
			fin_cov = '0;
		end else begin
			fin_cov = child_sum[LEN_W-1:0];
		end
	end

	// Memory access selection.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = t_idx;
		mem_we    = 1'b0;
		mem_waddr = t_idx;
		mem_wdata = {t_cnt, fin_cov};
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_RD: begin
				mem_re = 1'b1;
			end
			S_LEFT: begin
				mem_re    = !fr_vl[sp_q];
				mem_raddr = idx_l;
			end
			S_RIGHT: begin
				mem_re    = !fr_vr[sp_q];
				mem_raddr = idx_r;
			end
			S_FIN: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			node_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata <= node_mem[mem_raddr];
		end
	end

	// Stack frames and per-request payload.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					fr_idx[0] <= AW'(1);
					fr_i[0]   <= range_low_q;
					fr_j[0]   <= range_high_q;
					fr_a[0]   <= interval_low;
					fr_b[0]   <= interval_high;
					op_q      <= op;
				end
			end
			S_DEC: begin
				fr_lv[sp_q] <= '0;
				fr_rv[sp_q] <= '0;
				if (t_full) begin
					fr_cnt[sp_q] <= cnt_new;
					fr_vl[sp_q]  <= 1'b0;
					fr_vr[sp_q]  <= 1'b0;
				end else begin
					fr_cnt[sp_q] <= rd_cnt;
					fr_vl[sp_q]  <= (t_a < t_mid);
					fr_vr[sp_q]  <= (t_b > t_mid);
				end
			end
			S_LEFT: begin
				if (fr_vl[sp_q]) begin
					fr_idx[sp_q + SPW'(1)] <= idx_l;
					fr_i[sp_q + SPW'(1)]   <= t_i;
					fr_j[sp_q + SPW'(1)]   <= t_mid;
					fr_a[sp_q + SPW'(1)]   <= t_a;
					fr_b[sp_q + SPW'(1)]   <= left_b;
				end
			end
			S_LW: begin
				fr_lv[sp_q] <= rd_cov;
			end
			S_RIGHT: begin
				if (fr_vr[sp_q]) begin
					fr_idx[sp_q + SPW'(1)] <= idx_r;
					fr_i[sp_q + SPW'(1)]   <= t_mid;
					fr_j[sp_q + SPW'(1)]   <= t_j;
					fr_a[sp_q + SPW'(1)]   <= right_a;
					fr_b[sp_q + SPW'(1)]   <= t_b;
				end
			end
			S_RW: begin
				fr_rv[sp_q] <= rd_cov;
			end
			S_FIN: begin
				ret_q       <= fin_cov;
				ret_right_q <= t_idx[0];
			end
			S_RET: begin
				if (ret_right_q) begin
					fr_rv[sp_q] <= ret_q;
				end else begin
					fr_lv[sp_q] <= ret_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer, configuration and result slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			sp_q           <= '0;
			range_low_q    <= stcm_pkg::RANGE_LOW_RST;
			range_high_q   <= stcm_pkg::RANGE_HIGH_RST;
			root_len_q     <= '0;
			out_valid_q    <= 1'b0;
			res_measure_q  <= '0;
			res_rejected_q <= 1'b0;
		end else begin
			if (out_take) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				// A new range rebuilds the tree: clear every node again.
				unique case (cfg_index)
					stcm_pkg::REG_RANGE_LOW:  range_low_q  <= cfg_data;
					stcm_pkg::REG_RANGE_HIGH: range_high_q <= cfg_data;
					default: begin
					end
				endcase
				state_q    <= S_CLEAR;
				clr_q      <= '0;
				sp_q       <= '0;
				root_len_q <= '0;
			end else begin
				unique case (state_q)
					S_CLEAR: begin
						clr_q <= clr_q + AW'(1);
						if (clr_q == AW'(NODE_COUNT - 1)) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (in_accept) begin
							if (req_reject) begin
								out_valid_q    <= 1'b1;
								res_measure_q  <= range_ok ?
									stcm_pkg::MeasW'(root_len_q) : '0;
								res_rejected_q <= 1'b1;
							end else begin
								sp_q    <= '0;
								state_q <= S_RD;
							end
						end
					end
					S_RD: begin
						state_q <= S_DEC;
					end
					S_DEC: begin
						if (t_full && (t_leaf || (cnt_new > 0))) begin
							state_q <= S_FIN;
						end else if (!t_full && t_leaf) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_LEFT;
						end
					end
					S_LEFT: begin
						if (fr_vl[sp_q]) begin
							sp_q    <= sp_q + SPW'(1);
							state_q <= S_RD;
						end else begin
							state_q <= S_LW;
						end
					end
					S_LW: begin
						state_q <= S_RIGHT;
					end
					S_RIGHT: begin
						if (fr_vr[sp_q]) begin
							sp_q    <= sp_q + SPW'(1);
							state_q <= S_RD;
						end else begin
							state_q <= S_RW;
						end
					end
					S_RW: begin
						state_q <= S_FIN;
					end
					S_FIN: begin
						if (sp_q == '0) begin
							root_len_q     <= fin_cov;
							out_valid_q    <= 1'b1;
							res_measure_q  <= stcm_pkg::MeasW'(fin_cov);
							res_rejected_q <= 1'b0;
							state_q        <= S_IDLE;
						end else begin
							sp_q    <= sp_q - SPW'(1);
							state_q <= S_RET;
						end
					end
					S_RET: begin
						state_q <= ret_right_q ? S_FIN : S_RIGHT;
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	// The stack never grows past the tree height.
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(LVL - 1))
		else $error("traversal stack overflow");

	// The sequencer rests only with an empty stack.
	a_idle_sp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> sp_q == '0)
		else $error("idle with frames on the stack");

	// Finishing the root produces a result unless a configuration write comes with it.
	a_root_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && sp_q == '0 && !cfg_we) |=> out_valid_q)
		else $error("root finished without a result");

	// An accepted request that passes the checks starts a traversal.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && !req_reject && !cfg_we) |=> state_q == S_RD)
		else $error("valid request did not start a traversal");
`endif

endmodule
`default_nettype wire
